FILE: src/wavhp_pkg.sv
// Package: shared types and constants of the WAV header parser.
`timescale 1ns / 1ps
package wavhp_pkg;

    // Parse phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEAD,
        PH_SCAN,
        PH_LEN,
        PH_WAIT,
        PH_DONE
    } t_phase;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MAGIC = 2'd1,
        ST_NO_DATA   = 2'd2,
        ST_TRUNC     = 2'd3
    } t_status;

    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned CHECK_W  = 17;  // scan offset, may step 4 past the limit
    localparam int unsigned HDR_W    = 17;
    localparam int unsigned CMP_W    = 33;  // wide enough for 20 + fmt length

    localparam logic [31:0] MAGIC_RIFF = 32'h5249_4646;
    localparam logic [31:0] MAGIC_WAVE = 32'h5741_5645;
    localparam logic [31:0] MAGIC_FMT  = 32'h666D_7420;
    localparam logic [31:0] MAGIC_DATA = 32'h6461_7461;

    localparam logic [LIMIT_W-1:0] SCAN_LIMIT_RST = 16'd4096;
    localparam logic [15:0]        FMT_PCM        = 16'd1;

    // One result beat
    typedef struct packed {
        t_status           status;
        logic [15:0]       format_tag;
        logic              is_pcm;
        logic [15:0]       channel_count;
        logic [31:0]       rate_hz;
        logic [15:0]       bits_per_sample;
        logic [31:0]       data_length;
        logic [HDR_W-1:0]  header_bytes;
    } t_result;

endpackage

FILE: src/wav_header_parser_unit.sv
// Module: top level of the streaming RIFF/WAVE header parser.
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// in        sink       i_in_valid / o_in_ready  i_byte_value, i_first_byte, i_last_byte
// out       source     o_out_valid / i_out_ready o_status, o_format_tag, o_is_pcm,
//                                               o_channel_count, o_rate_hz,
//                                               o_bits_per_sample, o_data_length,
//                                               o_header_bytes
// cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_data (scan limit)
//
// One byte beat per cycle while no stalled result blocks input. Each byte is
// parsed in the cycle it is accepted and its result, if any, lands in the output register on that edge.
// The output register is the only stage; input is taken whenever it is empty
// or being drained, so a stalled result blocks input only while it waits.
// Synchronous active-low reset returns to idle (waiting for a first-byte mark)
// and sets the scan limit to 4096. Config writes are always ready.
module wav_header_parser_unit
    import wavhp_pkg::*;
#(
    parameter int unsigned POS_WIDTH = 17
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_byte_value,
    input  logic               i_first_byte,
    input  logic               i_last_byte,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [15:0]        o_format_tag,
    output logic               o_is_pcm,
    output logic [15:0]        o_channel_count,
    output logic [31:0]        o_rate_hz,
    output logic [15:0]        o_bits_per_sample,
    output logic [31:0]        o_data_length,
    output logic [HDR_W-1:0]   o_header_bytes,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    logic [LIMIT_W-1:0] r_scan_limit;
    logic               r_out_valid, n_out_valid;
    t_result            r_out;

    logic               in_acc;
    logic               res_valid;
    t_result            res;

    // Accept while the output register is empty or its beat leaves this cycle
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    wavhp_parse #(
        .POS_WIDTH (POS_WIDTH)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (in_acc),
        .i_byte_value (i_byte_value),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_scan_limit (r_scan_limit),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_comb begin
        if (res_valid)        n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else                  n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_scan_limit <= SCAN_LIMIT_RST;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) r_scan_limit <= i_cfg_data;
        end
    end

    // result payload, loaded only with a new result beat
    always_ff @(posedge i_clk) begin
        if (res_valid) r_out <= res;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out.status;
    assign o_format_tag      = r_out.format_tag;
    assign o_is_pcm          = r_out.is_pcm;
    assign o_channel_count   = r_out.channel_count;
    assign o_rate_hz         = r_out.rate_hz;
    assign o_bits_per_sample = r_out.bits_per_sample;
    assign o_data_length     = r_out.data_length;
    assign o_header_bytes    = r_out.header_bytes;

    // a result beat only appears after an accepted byte
    a_out_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_acc))
        else $error("result without accepted byte");

    // a waiting result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(r_out))
        else $error("result beat dropped or changed while stalled");

    // input is never blocked while the output register is empty
    a_in_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

endmodule

FILE: src/wavhp_parse.sv
// Module: per-byte parse state and result decision for the WAV header parser.
`timescale 1ns / 1ps
module wavhp_parse
    import wavhp_pkg::*;
#(
    parameter int unsigned POS_WIDTH = 17
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte_value,
    input  logic               i_first_byte,
    input  logic               i_last_byte,
    input  logic [LIMIT_W-1:0] i_scan_limit,
    output logic               o_res_valid,
    output t_result            o_res
);

    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    t_phase               r_phase, n_phase;
    logic [POS_WIDTH-1:0] r_pos, n_pos;
    logic [31:0]          r_window, n_window;
    logic [31:0]          r_fmt_len, n_fmt_len;
    logic [15:0]          r_code, n_code;
    logic [15:0]          r_chan, n_chan;
    logic [31:0]          r_rate, n_rate;
    logic [15:0]          r_bits, n_bits;
    logic [CHECK_W-1:0]   r_check, n_check;
    logic [CHECK_W-1:0]   r_match, n_match;

    logic                 active, step;
    t_phase               cur_phase;
    logic [CMP_W-1:0]     pos_x;
    logic [31:0]          win_base, win_sh;
    logic [31:0]          fmt_base;
    logic [15:0]          code_base, chan_base, bits_base;
    logic [31:0]          rate_base;

    logic                 bad_magic, head_end, head_over;
    logic [CMP_W-1:0]     nc_head;
    logic                 scan_hit, data_hit, scan_over;
    logic [CHECK_W-1:0]   nc_scan;
    logic                 len_end, at35;

    logic                 res_ok, res_err;
    t_status              res_status;

    // Byte position, window shift and field latches
    always_comb begin
        active    = i_first_byte || (r_phase != PH_IDLE && r_phase != PH_DONE);
        step      = i_step && active;
        cur_phase = i_first_byte ? PH_HEAD : r_phase;
        n_pos     = i_first_byte ? '0 : ((r_pos != POS_MAX) ? r_pos + 1'b1 : r_pos);
        pos_x     = {{(CMP_W-POS_WIDTH){1'b0}}, n_pos};

        win_base  = i_first_byte ? '0 : r_window;
        win_sh    = (cur_phase != PH_WAIT) ? {win_base[23:0], i_byte_value} : win_base;
        fmt_base  = i_first_byte ? '0 : r_fmt_len;
        code_base = i_first_byte ? '0 : r_code;
        chan_base = i_first_byte ? '0 : r_chan;
        rate_base = i_first_byte ? '0 : r_rate;
        bits_base = i_first_byte ? '0 : r_bits;

        n_fmt_len = (pos_x >= CMP_W'(16) && pos_x <= CMP_W'(19))
                  ? {i_byte_value, fmt_base[31:8]} : fmt_base;
        n_code    = (pos_x == CMP_W'(20) || pos_x == CMP_W'(21))
                  ? {i_byte_value, code_base[15:8]} : code_base;
        n_chan    = (pos_x == CMP_W'(22) || pos_x == CMP_W'(23))
                  ? {i_byte_value, chan_base[15:8]} : chan_base;
        n_rate    = (pos_x >= CMP_W'(24) && pos_x <= CMP_W'(27))
                  ? {i_byte_value, rate_base[31:8]} : rate_base;
        n_bits    = (pos_x == CMP_W'(34) || pos_x == CMP_W'(35))
                  ? {i_byte_value, bits_base[15:8]} : bits_base;
    end

    // Compare events of this byte
    always_comb begin
        bad_magic = (pos_x == CMP_W'(3)  && win_sh != MAGIC_RIFF) ||
                    (pos_x == CMP_W'(11) && win_sh != MAGIC_WAVE) ||
                    (pos_x == CMP_W'(15) && win_sh != MAGIC_FMT);
        head_end  = (pos_x == CMP_W'(19));
        nc_head   = CMP_W'(20) + {1'b0, n_fmt_len};
        head_over = nc_head > {{(CMP_W-LIMIT_W){1'b0}}, i_scan_limit};

        scan_hit  = pos_x == ({{(CMP_W-CHECK_W){1'b0}}, r_check} + CMP_W'(3));
        data_hit  = (win_sh == MAGIC_DATA);
        nc_scan   = r_check + CHECK_W'(4);
        scan_over = nc_scan > {{(CHECK_W-LIMIT_W){1'b0}}, i_scan_limit};

        len_end   = pos_x == ({{(CMP_W-CHECK_W){1'b0}}, r_match} + CMP_W'(7));
        at35      = (pos_x >= CMP_W'(35));
    end

    // Next phase and scan registers
    always_comb begin
        n_phase    = cur_phase;
        n_check    = i_first_byte ? '0 : r_check;
        n_match    = i_first_byte ? '0 : r_match;
        n_window   = win_sh;
        res_ok     = 1'b0;
        res_err    = 1'b0;
        res_status = ST_OK;
        case (cur_phase)
            PH_HEAD: begin
                if (bad_magic) begin
                    res_err    = 1'b1;
                    res_status = ST_BAD_MAGIC;
                end else if (head_end) begin
                    n_check = nc_head[CHECK_W-1:0];
                    if (head_over) begin
                        res_err    = 1'b1;
                        res_status = ST_NO_DATA;
                    end else begin
                        n_phase = PH_SCAN;
                    end
                end
            end
            PH_SCAN: begin
                if (scan_hit) begin
                    if (data_hit) begin
                        n_match = r_check;
                        n_phase = PH_LEN;
                    end else begin
                        n_check = nc_scan;
                        if (scan_over) begin
                            res_err    = 1'b1;
                            res_status = ST_NO_DATA;
                        end
                    end
                end
            end
            PH_LEN: begin
                if (len_end) begin
                    n_window = {win_sh[7:0], win_sh[15:8], win_sh[23:16], win_sh[31:24]};
                    if (at35) res_ok = 1'b1;
                    else      n_phase = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (at35) res_ok = 1'b1;
            end
            default: ;
        endcase
        // a result due on the last byte wins over truncation
        if (!res_ok && !res_err && i_last_byte) begin
            res_err    = 1'b1;
            res_status = ST_TRUNC;
        end
        if (res_ok || res_err) n_phase = PH_DONE;
    end

    // Result beat
    always_comb begin
        o_res_valid = step && (res_ok || res_err);
        o_res       = '0;
        o_res.status = res_status;
        if (res_ok) begin
            o_res.format_tag      = n_code;
            o_res.is_pcm          = (n_code == FMT_PCM);
            o_res.channel_count   = n_chan;
            o_res.rate_hz         = n_rate;
            o_res.bits_per_sample = n_bits;
            o_res.data_length     = n_window;
            o_res.header_bytes    = n_match + HDR_W'(8);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
        end else if (step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_window  <= n_window;
            r_fmt_len <= n_fmt_len;
            r_code    <= n_code;
            r_chan    <= n_chan;
            r_rate    <= n_rate;
            r_bits    <= n_bits;
            r_check   <= n_check;
            r_match   <= n_match;
        end
    end

    // a result always closes the parse
    a_done_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> r_phase == PH_DONE)
        else $error("parse not closed after result");

    // idle is only left by a first byte, so the position stays at zero
    a_idle_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_pos == '0)
        else $error("position moved while idle");

    // the data chunk can not start before offset 20
    a_ok_header_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.status == ST_OK |-> o_res.header_bytes >= HDR_W'(28))
        else $error("header size below minimum");

endmodule
